### sv/assert_macros.svh
// assertion macros used by the port-level checker
// depends on nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, off in reset
`define ASSERT_IMPLY(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
// next-cycle implication, off in reset
`define ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);
`endif

### sv/exz_pkg.sv
// package for the euler xyz to zyx converter: q30 constants and atan table
// depends on nothing
package exz_pkg;
   localparam int QW = 64;
   typedef logic signed [QW-1:0] q_type;
   localparam q_type ONE_Q30 = 64'sd1073741824;
   localparam q_type PI_Q30 = 64'sd3373259426;
   localparam q_type HALF_PI_Q30 = 64'sd1686629713;
   localparam q_type GAIN_Q30 = 64'sd652032874;
   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
      32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
      32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
      32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
      32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000007,
      32'h00000003, 32'h00000001, 32'h00000000, 32'h00000000};
   // atan(2^-k) in q30
   function automatic q_type atan_q(input logic [4:0] k);
      atan_q = q_type'({32'd0, ATAN_TAB[k]});
   endfunction
   // q30 product rounded half up; operands are unit-range values that fit in 32 bits
   function automatic q_type mulq(input q_type a, input q_type b);
      logic signed [31:0] a32, b32;
      q_type p;
      a32 = a[31:0];
      b32 = b[31:0];
      p = q_type'(a32) * q_type'(b32) + 64'sd536870912;
      mulq = p >>> 30;
   endfunction
endpackage

### sv/euler_xyz_to_zyx_convert.sv
// euler xyz to zyx converter: fully pipelined, one word per cycle, busy is always low
// the output delay is set by the sine/cosine cordic,
// the matrix products, the 32-stage square root and the atan2 cordic chain
// throughput one word per cycle; reset clears only the valid bits
// depends on exz_pkg and exz_cordic_stage
module euler_xyz_to_zyx_convert #(
   parameter int ANGLE_BITS = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [ANGLE_BITS-1:0] req_angle_x_in,
   input  logic signed [ANGLE_BITS-1:0] req_angle_y_in,
   input  logic signed [ANGLE_BITS-1:0] req_angle_z_in,
   output logic rsp_valid,
   output logic signed [ANGLE_BITS-1:0] rsp_roll_out,
   output logic signed [ANGLE_BITS-2:0] rsp_pitch_out,
   output logic signed [ANGLE_BITS-1:0] rsp_yaw_out
);
   import exz_pkg::*;
   localparam int SH = 33 - ANGLE_BITS;
   localparam int NS = CORDIC_STAGES;
   localparam int SQ = 32;
   localparam int LAT = 2 * NS + SQ + 8;
   assign busy = 1'b0;

   // valid shift line
   logic [LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[LAT-2:0], start};
   end

   // stage 0: widen and fold into +-pi/2
   q_type a0_in [3], a0_ff [3];
   logic [2:0] neg0_in, neg0_ff;
   always_comb begin
      a0_in[0] = q_type'(req_angle_x_in) <<< SH;
      a0_in[1] = q_type'(req_angle_y_in) <<< SH;
      a0_in[2] = q_type'(req_angle_z_in) <<< SH;
      for (int i = 0; i < 3; i++) begin
         neg0_in[i] = 1'b0;
         if (a0_in[i] > HALF_PI_Q30) begin
            a0_in[i] = a0_in[i] - PI_Q30; neg0_in[i] = 1'b1;
         end else if (a0_in[i] < -HALF_PI_Q30) begin
            a0_in[i] = a0_in[i] + PI_Q30; neg0_in[i] = 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      a0_ff <= a0_in; neg0_ff <= neg0_in;
   end

   // sine/cosine cordic lanes
   q_type sx_q [3][NS+1], sy_q [3][NS+1], sz_q [3][NS+1];
   logic [2:0] neg_d [NS+1];
   assign neg_d[0] = neg0_ff;
   for (genvar l = 0; l < 3; l++) begin : g_sc
      assign sx_q[l][0] = GAIN_Q30;
      assign sy_q[l][0] = '0;
      assign sz_q[l][0] = a0_ff[l];
      for (genvar s = 0; s < NS; s++) begin : g_st
         exz_cordic_stage #(.SHIFT(s)) u_st (
            .clock(clock), .vector_mode(1'b0),
            .x_in(sx_q[l][s]), .y_in(sy_q[l][s]), .z_in(sz_q[l][s]),
            .x_out(sx_q[l][s+1]), .y_out(sy_q[l][s+1]), .z_out(sz_q[l][s+1]));
      end
   end
   for (genvar s = 0; s < NS; s++) begin : g_negd
      logic [2:0] n_ff;
      always_ff @(posedge clock) n_ff <= neg_d[s];
      assign neg_d[s+1] = n_ff;
   end

   // apply fold sign
   q_type s_ff [3], c_ff [3];
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         s_ff[i] <= neg_d[NS][i] ? -sy_q[i][NS] : sy_q[i][NS];
         c_ff[i] <= neg_d[NS][i] ? -sx_q[i][NS] : sx_q[i][NS];
      end
   end

   // products, first level
   q_type sxsy_ff, cxsy_ff, r00_ff, cxsz_ff, sxsz_ff, sxcz_ff, r22_ff, cz1_ff, sz1_ff;
   always_ff @(posedge clock) begin
      sxsy_ff <= mulq(s_ff[0], s_ff[1]);
      cxsy_ff <= mulq(c_ff[0], s_ff[1]);
      r00_ff <= mulq(c_ff[1], c_ff[2]);
      cxsz_ff <= mulq(c_ff[0], s_ff[2]);
      sxsz_ff <= mulq(s_ff[0], s_ff[2]);
      sxcz_ff <= mulq(s_ff[0], c_ff[2]);
      r22_ff <= mulq(c_ff[0], c_ff[1]);
      cz1_ff <= c_ff[2];
      sz1_ff <= s_ff[2];
   end
   // products, second level and sums
   q_type r00b_ff, r10_ff, r20_ff, r21_ff, r22b_ff;
   always_ff @(posedge clock) begin
      r00b_ff <= r00_ff;
      r10_ff <= mulq(sxsy_ff, cz1_ff) + cxsz_ff;
      r20_ff <= sxsz_ff - mulq(cxsy_ff, cz1_ff);
      r21_ff <= sxcz_ff + mulq(cxsy_ff, sz1_ff);
      r22b_ff <= r22_ff;
   end
   // clamp r20, square
   q_type r20c_ff, r00c_ff, r10c_ff, r21c_ff, r22c_ff;
   always_ff @(posedge clock) begin
      if (r20_ff > ONE_Q30) r20c_ff <= ONE_Q30;
      else if (r20_ff < -ONE_Q30) r20c_ff <= -ONE_Q30;
      else r20c_ff <= r20_ff;
      r00c_ff <= r00b_ff; r10c_ff <= r10_ff; r21c_ff <= r21_ff; r22c_ff <= r22b_ff;
   end
   // clamped r20 fits in 32 bits, so the square is a 32 by 32 product
   logic signed [31:0] r20s;
   assign r20s = r20c_ff[31:0];
   logic [63:0] rad_ff;
   q_type r20d_ff, r00d_ff, r10d_ff, r21d_ff, r22d_ff;
   always_ff @(posedge clock) begin
      rad_ff <= 64'(ONE_Q30 * ONE_Q30 - q_type'(r20s) * q_type'(r20s));
      r20d_ff <= r20c_ff; r00d_ff <= r00c_ff; r10d_ff <= r10c_ff;
      r21d_ff <= r21c_ff; r22d_ff <= r22c_ff;
   end

   // floor square root, one result bit per stage (radicand below 2^61)
   logic [63:0] sv_q [SQ+1], sr_q [SQ+1];
   q_type sy0 [SQ+1], sx0 [SQ+1], sy1 [SQ+1], sx1 [SQ+1], sy2 [SQ+1];
   assign sv_q[0] = rad_ff;
   assign sr_q[0] = '0;
   assign sy0[0] = r10d_ff; assign sx0[0] = r00d_ff;
   assign sy1[0] = r21d_ff; assign sx1[0] = r22d_ff;
   assign sy2[0] = r20d_ff;
   for (genvar s = 0; s < SQ; s++) begin : g_sq
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * s);
      logic [63:0] v_ff, r_ff;
      q_type a_ff, b_ff, c2_ff, d_ff, e_ff;
      always_ff @(posedge clock) begin
         if (sv_q[s] >= sr_q[s] + BIT) begin
            v_ff <= sv_q[s] - (sr_q[s] + BIT);
            r_ff <= (sr_q[s] >> 1) + BIT;
         end else begin
            v_ff <= sv_q[s];
            r_ff <= sr_q[s] >> 1;
         end
         a_ff <= sy0[s]; b_ff <= sx0[s]; c2_ff <= sy1[s]; d_ff <= sx1[s]; e_ff <= sy2[s];
      end
      assign sv_q[s+1] = v_ff; assign sr_q[s+1] = r_ff;
      assign sy0[s+1] = a_ff; assign sx0[s+1] = b_ff;
      assign sy1[s+1] = c2_ff; assign sx1[s+1] = d_ff; assign sy2[s+1] = e_ff;
   end

   // atan2 pre-rotation into right half plane
   q_type vx_in [3], vy_in [3], vz_in [3], vx_ff [3], vy_ff [3], vz_ff [3];
   logic [2:0] zero_in, zero_ff;
   always_comb begin
      vy_in[0] = sy0[SQ]; vx_in[0] = sx0[SQ];
      vy_in[1] = sy1[SQ]; vx_in[1] = sx1[SQ];
      vy_in[2] = sy2[SQ]; vx_in[2] = q_type'(sr_q[SQ]);
      for (int i = 0; i < 3; i++) begin
         zero_in[i] = (vx_in[i] == 0) && (vy_in[i] == 0);
         vz_in[i] = '0;
         if (vx_in[i] < 0) begin
            if (vy_in[i] >= 0) begin
               {vx_in[i], vy_in[i]} = {vy_in[i], -vx_in[i]}; vz_in[i] = HALF_PI_Q30;
            end else begin
               {vx_in[i], vy_in[i]} = {-vy_in[i], vx_in[i]}; vz_in[i] = -HALF_PI_Q30;
            end
         end
      end
   end
   always_ff @(posedge clock) begin
      vx_ff <= vx_in; vy_ff <= vy_in; vz_ff <= vz_in; zero_ff <= zero_in;
   end

   // vectoring cordic lanes
   q_type tx_q [3][NS+1], ty_q [3][NS+1], tz_q [3][NS+1];
   logic [2:0] zd [NS+1];
   assign zd[0] = zero_ff;
   for (genvar l = 0; l < 3; l++) begin : g_at
      assign tx_q[l][0] = vx_ff[l];
      assign ty_q[l][0] = vy_ff[l];
      assign tz_q[l][0] = vz_ff[l];
      for (genvar s = 0; s < NS; s++) begin : g_st
         exz_cordic_stage #(.SHIFT(s)) u_st (
            .clock(clock), .vector_mode(1'b1),
            .x_in(tx_q[l][s]), .y_in(ty_q[l][s]), .z_in(tz_q[l][s]),
            .x_out(tx_q[l][s+1]), .y_out(ty_q[l][s+1]), .z_out(tz_q[l][s+1]));
      end
   end
   for (genvar s = 0; s < NS; s++) begin : g_zd
      logic [2:0] z_ff;
      always_ff @(posedge clock) z_ff <= zd[s];
      assign zd[s+1] = z_ff;
   end

   // round to output format and clamp
   localparam q_type PI_O = (PI_Q30 + (64'sd1 <<< (SH - 1))) >>> SH;
   localparam q_type HPI_O = (HALF_PI_Q30 + (64'sd1 <<< (SH - 1))) >>> SH;
   q_type ang [3], rnd [3];
   logic signed [ANGLE_BITS-1:0] roll_ff, yaw_ff;
   logic signed [ANGLE_BITS-2:0] pitch_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ang[i] = zd[NS][i] ? '0 : tz_q[i][NS];
      end
      ang[2] = -ang[2];
      for (int i = 0; i < 3; i++) begin
         rnd[i] = (ang[i] + (64'sd1 <<< (SH - 1))) >>> SH;
         if (i == 2) begin
            if (rnd[i] > HPI_O) rnd[i] = HPI_O;
            if (rnd[i] < -HPI_O) rnd[i] = -HPI_O;
         end else begin
            if (rnd[i] > PI_O) rnd[i] = PI_O;
            if (rnd[i] < -PI_O) rnd[i] = -PI_O;
         end
      end
   end
   always_ff @(posedge clock) begin
      yaw_ff <= rnd[0][ANGLE_BITS-1:0];
      roll_ff <= rnd[1][ANGLE_BITS-1:0];
      pitch_ff <= rnd[2][ANGLE_BITS-2:0];
   end
   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_roll_out = roll_ff;
   assign rsp_pitch_out = pitch_ff;
   assign rsp_yaw_out = yaw_ff;
endmodule

### sv/exz_cordic_stage.sv
// one cordic micro-rotation stage, rotation or vectoring mode, registered
// depends on exz_pkg
module exz_cordic_stage #(
   parameter int SHIFT = 0
) (
   input  logic clock,
   input  logic vector_mode,
   input  exz_pkg::q_type x_in,
   input  exz_pkg::q_type y_in,
   input  exz_pkg::q_type z_in,
   output exz_pkg::q_type x_out,
   output exz_pkg::q_type y_out,
   output exz_pkg::q_type z_out
);
   import exz_pkg::*;
   logic dir_up;
   q_type dx, dy, at;
   q_type x_ff, y_ff, z_ff, x_in_n, y_in_n, z_in_n;
   // shifted terms and direction
   always_comb begin
      dx = y_in >>> (SHIFT % 32);
      dy = x_in >>> (SHIFT % 32);
      at = atan_q(5'(SHIFT % 32));
      dir_up = vector_mode ? (y_in >= 0) : (z_in >= 0);
      if (dir_up ^ vector_mode) begin
         x_in_n = x_in - dx; y_in_n = y_in + dy; z_in_n = z_in - at;
      end else if (vector_mode) begin
         x_in_n = x_in + dx; y_in_n = y_in - dy; z_in_n = z_in + at;
      end else begin
         x_in_n = x_in + dx; y_in_n = y_in - dy; z_in_n = z_in + at;
      end
      if (vector_mode && !dir_up) begin
         x_in_n = x_in - dx; y_in_n = y_in + dy; z_in_n = z_in - at;
      end
   end
   always_ff @(posedge clock) begin
      x_ff <= x_in_n; y_ff <= y_in_n; z_ff <= z_in_n;
   end
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
endmodule

### sv/exz_checker.sv
// port-level checker for the euler converter, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module exz_checker #(
   parameter int ANGLE_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic signed [ANGLE_BITS-1:0] rsp_roll_out,
   input logic signed [ANGLE_BITS-2:0] rsp_pitch_out,
   input logic signed [ANGLE_BITS-1:0] rsp_yaw_out
);
   `ASSERT_IMPLY(a_busy_low, clock, reset, 1'b1, !busy, "busy raised")
   `ASSERT_NEXT(a_rst_quiet, clock, 1'b0, reset, !rsp_valid, "word after reset")
   `ASSERT_IMPLY(a_pitch_rng, clock, reset, rsp_valid, rsp_pitch_out <= 15'sd12868 && rsp_pitch_out >= -15'sd12868, "pitch range")
endmodule
bind euler_xyz_to_zyx_convert exz_checker #(.ANGLE_BITS(ANGLE_BITS)) u_exz_checker (.*);

### dv/euler_xyz_to_zyx_convert_checker.sv
// checker for the euler xyz to zyx converter: watches both channels, predicts, compares
// depends on exz_pkg for the q30 constants and the atan table
module euler_xyz_to_zyx_convert_checker #(
   parameter int ANGLE_BITS = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic busy,
   input  logic signed [ANGLE_BITS-1:0] req_angle_x_in,
   input  logic signed [ANGLE_BITS-1:0] req_angle_y_in,
   input  logic signed [ANGLE_BITS-1:0] req_angle_z_in,
   input  logic rsp_valid,
   input  logic signed [ANGLE_BITS-1:0] rsp_roll_out,
   input  logic signed [ANGLE_BITS-2:0] rsp_pitch_out,
   input  logic signed [ANGLE_BITS-1:0] rsp_yaw_out,
   output int errors,
   output int pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import exz_pkg::*;

   localparam int SHIFT_Q = 33 - ANGLE_BITS;

   typedef struct {
      logic signed [ANGLE_BITS-1:0] roll;
      logic signed [ANGLE_BITS-2:0] pitch;
      logic signed [ANGLE_BITS-1:0] yaw;
   } zyx_angles_type;

   zyx_angles_type expected_angles [$];

   // rounded q30 product
   function automatic longint qmul(input longint a, input longint b);
      qmul = (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic longint atan_entry(input int k);
      atan_entry = longint'({32'd0, ATAN_TAB[k & 31]});
   endfunction

   // rotation-mode cordic after folding into +-pi/2
   function automatic void sin_cos(input longint ang, output longint s, output longint c);
      longint x, y, z, dx, dy;
      bit flip;
      flip = 0;
      x = GAIN_Q30;
      y = 0;
      if (ang > HALF_PI_Q30) begin
         ang = ang - PI_Q30;
         flip = 1;
      end else if (ang < -HALF_PI_Q30) begin
         ang = ang + PI_Q30;
         flip = 1;
      end
      z = ang;
      for (int k = 0; k < CORDIC_STAGES; k++) begin
         dx = y >>> (k & 31);
         dy = x >>> (k & 31);
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - atan_entry(k);
         end else begin
            x = x + dx; y = y - dy; z = z + atan_entry(k);
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   // vectoring-mode cordic, quarter turn first when x is negative
   function automatic longint vector_angle(input longint y, input longint x);
      longint z, t, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = HALF_PI_Q30;
         end else begin
            x = -y; y = t; z = -HALF_PI_Q30;
         end
      end
      for (int k = 0; k < CORDIC_STAGES; k++) begin
         dx = y >>> (k & 31);
         dy = x >>> (k & 31);
         if (y >= 0) begin
            x = x + dx; y = y - dy; z = z + atan_entry(k);
         end else begin
            x = x - dx; y = y + dy; z = z - atan_entry(k);
         end
      end
      return z;
   endfunction

   // floor square root
   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint to_out(input longint z, input longint lim);
      longint r;
      r = (z + (64'sd1 <<< (SHIFT_Q - 1))) >>> SHIFT_Q;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic zyx_angles_type convert_xyz(input logic signed [ANGLE_BITS-1:0] ax,
         input logic signed [ANGLE_BITS-1:0] ay, input logic signed [ANGLE_BITS-1:0] az);
      longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
      longint r00, r10, r20, r21, r22, cp, pi_o, hpi_o, roll, pitch, yaw;
      zyx_angles_type res;
      sin_cos(longint'(ax) <<< SHIFT_Q, sx, cx);
      sin_cos(longint'(ay) <<< SHIFT_Q, sy, cy);
      sin_cos(longint'(az) <<< SHIFT_Q, sz, cz);
      sxsy = qmul(sx, sy);
      cxsy = qmul(cx, sy);
      r00 = qmul(cy, cz);
      r10 = qmul(sxsy, cz) + qmul(cx, sz);
      r20 = qmul(sx, sz) - qmul(cxsy, cz);
      r21 = qmul(sx, cz) + qmul(cxsy, sz);
      r22 = qmul(cx, cy);
      // clamp the asin argument
      if (r20 > ONE_Q30) r20 = ONE_Q30;
      if (r20 < -ONE_Q30) r20 = -ONE_Q30;
      cp = longint'(floor_sqrt(longint'(ONE_Q30 * ONE_Q30 - r20 * r20)));
      pi_o = (PI_Q30 + (64'sd1 <<< (SHIFT_Q - 1))) >>> SHIFT_Q;
      hpi_o = (HALF_PI_Q30 + (64'sd1 <<< (SHIFT_Q - 1))) >>> SHIFT_Q;
      yaw = to_out(vector_angle(r10, r00), pi_o);
      roll = to_out(vector_angle(r21, r22), pi_o);
      pitch = to_out(-vector_angle(r20, cp), hpi_o);
      res.roll = roll[ANGLE_BITS-1:0];
      res.pitch = pitch[ANGLE_BITS-2:0];
      res.yaw = yaw[ANGLE_BITS-1:0];
      return res;
   endfunction

   assign pending = expected_angles.size();

   // accept words and results on the clock edge
   always @(posedge clock) begin
      zyx_angles_type want;
      if (reset) begin
         errors <= 0;
      end else begin
         if (start && !busy)
            expected_angles.push_back(convert_xyz(req_angle_x_in, req_angle_y_in,
               req_angle_z_in));
         if (rsp_valid) begin
            if (expected_angles.size() == 0) begin
               $display("%0t unexpected word: roll %0d pitch %0d yaw %0d", $time,
                  rsp_roll_out, rsp_pitch_out, rsp_yaw_out);
               errors <= errors + 1;
            end else begin
               want = expected_angles.pop_front();
               if (rsp_roll_out !== want.roll || rsp_pitch_out !== want.pitch ||
                     rsp_yaw_out !== want.yaw) begin
                  $display("%0t mismatch: expected roll %0d pitch %0d yaw %0d, got %0d %0d %0d",
                     $time, want.roll, want.pitch, want.yaw, rsp_roll_out, rsp_pitch_out,
                     rsp_yaw_out);
                  errors <= errors + 1;
               end
            end
         end
      end
   end
endmodule

### dv/euler_xyz_to_zyx_convert_tb.sv
// testbench top for the euler xyz to zyx converter: stimulus, clock, reset and verdict
// depends on euler_xyz_to_zyx_convert and euler_xyz_to_zyx_convert_checker
module euler_xyz_to_zyx_convert_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AB = 16;
   localparam int PIPE_WAIT = 3 * 16 + 2 * AB + 40;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_WORDS = 1250;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [AB-1:0] req_angle_x_in = 0, req_angle_y_in = 0, req_angle_z_in = 0;
   logic rsp_valid;
   logic signed [AB-1:0] rsp_roll_out, rsp_yaw_out;
   logic signed [AB-2:0] rsp_pitch_out;
   int errors, pending;
   int cycles = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   euler_xyz_to_zyx_convert dut (.*);

   euler_xyz_to_zyx_convert_checker chk (.*);

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("euler_xyz_to_zyx_convert_tb: done, errors");
         $finish;
      end
   end

   // present one word and hold it until taken
   task automatic send_word(input logic [AB-1:0] ax, input logic [AB-1:0] ay,
         input logic [AB-1:0] az);
      logic held;
      req_angle_x_in <= ax;
      req_angle_y_in <= ay;
      req_angle_z_in <= az;
      start <= 1;
      do begin
         @(negedge clock);
         held = busy;
         @(posedge clock);
      end while (held);
   endtask

   task automatic idle_cycle();
      start <= 0;
      @(posedge clock);
   endtask

   // mix of full range, principal range, near gimbal lock and tiny angles
   function automatic logic [AB-1:0] pick_angle();
      case ($urandom_range(0, 3))
         0: return AB'($urandom);
         1: return AB'($urandom_range(0, 2 * 25736) - 25736);
         2: return AB'(($urandom_range(0, 1) ? 12868 : -12868) + $urandom_range(0, 80) - 40);
         default: return AB'($urandom_range(0, 64) - 32);
      endcase
   endfunction

   logic [AB-1:0] directed [21][3] = '{
      '{16'h0000, 16'h0000, 16'h0000}, '{16'h7FFF, 16'h7FFF, 16'h7FFF},
      '{16'h8000, 16'h8000, 16'h8000}, '{16'h7FFF, 16'h8000, 16'h0001},
      '{16'hFFFF, 16'h0001, 16'hFFFF}, '{16'd25736, 16'd0, 16'd0},
      '{16'd0, 16'd25736, 16'd0}, '{16'd0, 16'd0, 16'd25736},
      '{-16'sd25736, -16'sd25736, -16'sd25736}, '{16'd0, 16'd12868, 16'd0},
      '{16'd0, -16'sd12868, 16'd0}, '{16'd3000, 16'd12868, 16'd5000},
      '{16'd3000, 16'd12869, -16'sd5000}, '{16'd12868, 16'd12868, 16'd12868},
      '{-16'sd12868, 16'd0, 16'd12868}, '{16'd25737, -16'sd25737, 16'd25737},
      '{16'h5555, 16'hAAAA, 16'h5555}, '{16'hAAAA, 16'h5555, 16'hAAAA},
      '{16'd8192, 16'd4096, -16'sd8192}, '{16'd1, 16'd1, 16'd1},
      '{16'd20000, 16'd12860, -16'sd20000}};

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed corners: extremes, pi, gimbal lock, wrap beyond pi
      foreach (directed[i]) send_word(directed[i][0], directed[i][1], directed[i][2]);
      idle_cycle();

      // random words with sparse gaps, a back-to-back stretch, and one drain pause
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 700) begin
            start <= 0;
            while (pending != 0) @(posedge clock);
         end
         if (!(n >= 300 && n < 500))
            while ($urandom_range(0, 99) < 14) idle_cycle();
         send_word(pick_angle(), pick_angle(), pick_angle());
      end
      start <= 0;

      while (pending != 0) @(posedge clock);
      repeat (PIPE_WAIT) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("euler_xyz_to_zyx_convert_tb: done, clean");
      end else begin
         $display("euler_xyz_to_zyx_convert_tb: done, errors");
      end
      $finish;
   end
endmodule

### filelist.f
+incdir+sv
sv/exz_pkg.sv
sv/exz_cordic_stage.sv
sv/euler_xyz_to_zyx_convert.sv
sv/exz_checker.sv
dv/euler_xyz_to_zyx_convert_checker.sv
dv/euler_xyz_to_zyx_convert_tb.sv
